### rtl/uart_receiver_with_edge_resync_top_assert.svh
// Assertion macros for the UART receiver RTL.
// Included by uart_receiver_with_edge_resync_top.sv; expects clk and rst in scope.
`ifndef UART_RECEIVER_WITH_EDGE_RESYNC_TOP_ASSERT_SVH
`define UART_RECEIVER_WITH_EDGE_RESYNC_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define UART_RX_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("uart_rx assertion failed");
`define UART_RX_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uart_rx assertion failed");
`define UART_RX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uart_rx assertion failed");
`else
`define UART_RX_ASSERT(label, cond)
`define UART_RX_ASSERT_IMP(label, ante, cons)
`define UART_RX_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/uart_rx_pkg.sv
// Package for the UART receiver: register indexes, reset values, receiver state type.
// No dependencies.
package uart_rx_pkg;

  typedef enum logic [0:0] {
    REG_CYCLES_PER_BIT = 1'b0,
    REG_BITS_PER_FRAME = 1'b1
  } cfg_reg_t;

  localparam logic [15:0] CYCLES_PER_BIT_RESET = 16'd1666;
  localparam logic [3:0]  BITS_PER_FRAME_RESET = 4'd10;
  localparam logic [3:0]  FRAME_MIN            = 4'd10;
  localparam logic [3:0]  FRAME_MAX            = 4'd12;
  localparam int          FRAME_W              = 12;

  typedef struct packed {
    logic               prev_level;
    logic               active;
    logic [15:0]        countdown;
    logic [3:0]         bit_pos;
    logic [FRAME_W-1:0] frame;
  } rx_state_t;

endpackage

### rtl/uart_receiver_with_edge_resync_top.sv
// UART receiver with falling-edge resync and an overwrite-on-full receive queue.
// Depends on uart_rx_pkg and uart_receiver_with_edge_resync_top_assert.svh.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | rx_valid / rx_stall    | line_level, pop_request
//  result   | res_valid / res_stall  | pop_valid, pop_data, queue_length, busy_res
//  config   | APB psel/penable/...   | cycles_per_bit @0x0, bits_per_frame @0x4
//
// One request accepted per cycle while rx_stall is low; its result passes the queue
// read stage, then the output register, and is offered there on res_valid.
// The receiver update is combinational; the queue memory does one read and one
// write per cycle.
// rst is synchronous; the queue store is not cleared (only written slots are read).
// A stalled result holds; one more request is taken while it waits, then rx_stall rises.
module uart_receiver_with_edge_resync_top #(
  parameter int QUEUE_DEPTH = 32,
  localparam int AddrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rx_valid,
  output logic            rx_stall,
  input  logic            line_level,
  input  logic            pop_request,
  output logic            res_valid,
  input  logic            res_stall,
  output logic            pop_valid,
  output logic [7:0]      pop_data,
  output logic [CntW-1:0] queue_length,
  output logic            busy_res,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

`include "uart_receiver_with_edge_resync_top_assert.svh"

  logic [15:0] cycles_per_bit;
  logic [3:0]  bits_per_frame;

  uart_rx_pkg::rx_state_t st, st_next;

  logic [7:0]      byte_store [QUEUE_DEPTH];
  logic [7:0]      mem_q;
  logic [AddrW-1:0] oldest_slot, oldest_slot_next;
  logic [CntW-1:0]  held_count, held_count_next;

  logic            s1_valid;
  logic            s1_pop_valid;
  logic [CntW-1:0] s1_queue_length;
  logic            s1_busy;

  logic accept, s1_advance, cfg_write;

  logic            pop_ok, push;
  logic [7:0]      push_data;
  logic [AddrW-1:0] waddr;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_bit <= uart_rx_pkg::CYCLES_PER_BIT_RESET;
      bits_per_frame <= uart_rx_pkg::BITS_PER_FRAME_RESET;
    end else if (cfg_write) begin
      unique case (uart_rx_pkg::cfg_reg_t'(paddr[2]))
        uart_rx_pkg::REG_CYCLES_PER_BIT: cycles_per_bit <= pwdata[15:0];
        uart_rx_pkg::REG_BITS_PER_FRAME: bits_per_frame <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (uart_rx_pkg::cfg_reg_t'(paddr[2]))
      uart_rx_pkg::REG_CYCLES_PER_BIT: prdata = {16'd0, cycles_per_bit};
      uart_rx_pkg::REG_BITS_PER_FRAME: prdata = {28'd0, bits_per_frame};
      default:                         prdata = 32'd0;
    endcase
  end

  // Handshake
  assign s1_advance = !res_valid || !res_stall;
  assign rx_stall   = s1_valid && !s1_advance;
  assign accept     = rx_valid && !rx_stall;

  // Receiver and queue update for one tick
  always_comb begin
    logic [3:0]               frame_len;
    logic [uart_rx_pkg::FRAME_W-1:0] frame_new;
    logic [3:0]               pos_new;
    logic [CntW-1:0]          held1;
    logic [AddrW-1:0]         oldest1;
    logic [AddrW:0]           wsum;

    st_next   = st;
    push      = 1'b0;
    push_data = 8'd0;
    frame_new = st.frame;
    pos_new   = st.bit_pos;

    if (bits_per_frame < uart_rx_pkg::FRAME_MIN) frame_len = uart_rx_pkg::FRAME_MIN;
    else if (bits_per_frame > uart_rx_pkg::FRAME_MAX) frame_len = uart_rx_pkg::FRAME_MAX;
    else frame_len = bits_per_frame;

    if (st.prev_level && !line_level) begin
      if (!st.active) begin
        st_next.active  = 1'b1;
        st_next.bit_pos = 4'd0;
        st_next.frame   = '0;
      end
      st_next.countdown = {1'b0, cycles_per_bit[15:1]};
    end else if (st.active) begin
      if (st.countdown[15:1] == 15'd0) begin
        st_next.countdown = cycles_per_bit;
        if (st.bit_pos == 4'd0) begin
          if (line_level) st_next.active = 1'b0;
          else st_next.bit_pos = 4'd1;
        end else begin
          frame_new = st.frame
                    | (uart_rx_pkg::FRAME_W'(line_level) << st.bit_pos);
          pos_new   = st.bit_pos + 4'd1;
          if (pos_new >= frame_len) begin
            if (!frame_new[frame_len - 4'd1]) begin
              st_next.active = 1'b0;
            end else begin
              push      = 1'b1;
              push_data = frame_new[8:1];
            end
            st_next.frame   = '0;
            st_next.bit_pos = 4'd0;
          end else begin
            st_next.frame   = frame_new;
            st_next.bit_pos = pos_new;
          end
        end
      end else begin
        st_next.countdown = st.countdown - 16'd1;
      end
    end
    st_next.prev_level = line_level;

    // pop first, then push
    pop_ok  = pop_request && (held_count != '0);
    held1   = pop_ok ? held_count - CntW'(1) : held_count;
    if (pop_ok) oldest1 = (oldest_slot == AddrW'(QUEUE_DEPTH - 1)) ? '0
                                                                  : oldest_slot + AddrW'(1);
    else oldest1 = oldest_slot;

    oldest_slot_next = oldest1;
    held_count_next  = held1;
    wsum  = (AddrW+1)'(oldest1) + (AddrW+1)'(held1);
    if (wsum >= (AddrW+1)'(QUEUE_DEPTH)) wsum = wsum - (AddrW+1)'(QUEUE_DEPTH);
    waddr = wsum[AddrW-1:0];
    if (push) begin
      if (held1 >= CntW'(QUEUE_DEPTH)) begin
        waddr = oldest1;
        oldest_slot_next = (oldest1 == AddrW'(QUEUE_DEPTH - 1)) ? '0
                                                               : oldest1 + AddrW'(1);
      end else begin
        held_count_next = held1 + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev_level <= 1'b1;
      st.active     <= 1'b0;
      st.countdown  <= '0;
      st.bit_pos    <= '0;
      st.frame      <= '0;
      oldest_slot   <= '0;
      held_count    <= '0;
    end else if (accept) begin
      st          <= st_next;
      oldest_slot <= oldest_slot_next;
      held_count  <= held_count_next;
    end
  end

  // Queue memory: read of the old head before this tick's write
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= byte_store[oldest_slot];
      if (push) byte_store[waddr] <= push_data;
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop_valid    <= pop_ok;
      s1_queue_length <= held_count_next;
      s1_busy         <= st_next.active;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_valid && s1_advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      pop_valid    <= s1_pop_valid;
      pop_data     <= s1_pop_valid ? mem_q : 8'd0;
      queue_length <= s1_queue_length;
      busy_res     <= s1_busy;
    end
  end

  `UART_RX_ASSERT(held_in_range, held_count <= CntW'(QUEUE_DEPTH))
  `UART_RX_ASSERT_IMP(idle_pos_clear, !st.active, st.bit_pos == 4'd0)
  `UART_RX_ASSERT_NEXT(accept_fills_s1, accept, s1_valid)
  `UART_RX_ASSERT_IMP(no_pop_zero_data, res_valid && !pop_valid, pop_data == 8'd0)

endmodule

### bench/uart_rx_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the UART receiver: follows APB register writes, predicts the status of
// every accepted request and compares it field by field with the result channel.
// Depends on uart_rx_pkg.
module uart_rx_checker
  import uart_rx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_stall,
  input  logic        line_level,
  input  logic        pop_request,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic        pop_valid,
  input  logic [7:0]  pop_data,
  input  logic [5:0]  queue_length,
  input  logic        busy_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          pending
);

  localparam int FIFO_DEPTH = 32;

  typedef struct packed {
    logic       pop_valid;
    logic [7:0] pop_data;
    logic [5:0] queue_length;
    logic       busy;
  } rx_status_t;

  logic [15:0] cfg_cycles;
  logic [3:0]  cfg_frame;

  logic        prev_level;
  logic        receiving;
  logic [15:0] countdown;
  logic [3:0]  bit_pos;
  logic [11:0] frame;
  logic [7:0]  fifo [FIFO_DEPTH];
  logic [4:0]  head;
  logic [5:0]  held;

  rx_status_t expected_status[$];
  rx_status_t got;
  rx_status_t want;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch, %s", $time, msg);
    mismatches++;
  endtask

  // one clock tick of the receiver: pop, then edge or countdown, then push
  function automatic rx_status_t predict_tick(input logic level, input logic pop);
    rx_status_t r;
    logic [3:0] len;
    logic [4:0] slot;
    r = '0;
    len = (cfg_frame < FRAME_MIN) ? FRAME_MIN : (cfg_frame > FRAME_MAX) ? FRAME_MAX : cfg_frame;
    if (pop && held != 6'd0) begin
      r.pop_valid = 1'b1;
      r.pop_data = fifo[head];
      head = head + 5'd1;
      held = held - 6'd1;
    end
    if (prev_level && !level) begin
      if (!receiving) begin
        receiving = 1'b1;
        bit_pos = '0;
        frame = '0;
      end
      countdown = cfg_cycles >> 1;
    end else if (receiving) begin
      if (countdown <= 16'd1) begin
        countdown = cfg_cycles;
        if (bit_pos == 4'd0) begin
          if (level) receiving = 1'b0;
          else bit_pos = 4'd1;
        end else begin
          frame[bit_pos] = frame[bit_pos] | level;
          bit_pos = bit_pos + 4'd1;
          if (bit_pos >= len) begin
            if (!frame[len - 4'd1]) begin
              receiving = 1'b0;
            end else if (held == 6'(FIFO_DEPTH)) begin
              fifo[head] = frame[8:1];
              head = head + 5'd1;
            end else begin
              slot = head + held[4:0];
              fifo[slot] = frame[8:1];
              held = held + 6'd1;
            end
            frame = '0;
            bit_pos = '0;
          end
        end
      end else begin
        countdown = countdown - 16'd1;
      end
    end
    prev_level = level;
    r.queue_length = held;
    r.busy = receiving;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_cycles = CYCLES_PER_BIT_RESET;
      cfg_frame = BITS_PER_FRAME_RESET;
      prev_level = 1'b1;
      receiving = 1'b0;
      countdown = '0;
      bit_pos = '0;
      frame = '0;
      head = '0;
      held = '0;
      expected_status.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[2]))
          REG_CYCLES_PER_BIT: cfg_cycles = pwdata[15:0];
          REG_BITS_PER_FRAME: cfg_frame = pwdata[3:0];
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        got = '{pop_valid, pop_data, queue_length, busy_res};
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: %p", got));
        end else begin
          want = expected_status.pop_front();
          if (got.pop_valid !== want.pop_valid)
            report_mismatch($sformatf("pop_valid %b, want %b", got.pop_valid, want.pop_valid));
          if (got.pop_data !== want.pop_data)
            report_mismatch($sformatf("pop_data %h, want %h", got.pop_data, want.pop_data));
          if (got.queue_length !== want.queue_length)
            report_mismatch($sformatf("queue_length %0d, want %0d",
                                      got.queue_length, want.queue_length));
          if (got.busy !== want.busy)
            report_mismatch($sformatf("busy_res %b, want %b", got.busy, want.busy));
        end
      end
      if (rx_valid && !rx_stall)
        expected_status.push_back(predict_tick(line_level, pop_request));
    end
    pending = expected_status.size();
  end

endmodule

### bench/tb_uart_receiver_with_edge_resync_top.sv
`timescale 1ns / 1ps
// Top of the UART receiver bench: clock, reset, APB setup and serial-line stimulus.
// Instantiates the receiver and uart_rx_checker; depends on uart_rx_pkg.
module tb_uart_receiver_with_edge_resync_top;
  import uart_rx_pkg::*;

  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic        line_level = 1'b1;
  logic        pop_request = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        pop_valid;
  logic [7:0]  pop_data;
  logic [5:0]  queue_length;
  logic        busy_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   mismatches;
  int   pending;
  int   cycle_count = 0;
  int   ticks_sent = 0;
  int   stall_left = 0;
  bit   gaps_on = 1'b1;
  logic rx_taken = 1'b0;
  int   cur_cycles = CYCLES_PER_BIT_RESET;
  int   frame_len = BITS_PER_FRAME_RESET;

  uart_receiver_with_edge_resync_top dut (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall),
    .line_level(line_level), .pop_request(pop_request),
    .res_valid(res_valid), .res_stall(res_stall),
    .pop_valid(pop_valid), .pop_data(pop_data),
    .queue_length(queue_length), .busy_res(busy_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  uart_rx_checker rx_check (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall),
    .line_level(line_level), .pop_request(pop_request),
    .res_valid(res_valid), .res_stall(res_stall),
    .pop_valid(pop_valid), .pop_data(pop_data),
    .queue_length(queue_length), .busy_res(busy_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    rx_taken <= rx_valid && !rx_stall && !rst;
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("FAILURE");
    $finish;
  end

  // result-side backpressure in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (gaps_on && !rst && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 16);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  function automatic logic rand_pop(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic send_tick(input logic level, input logic pop);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    rx_valid <= 1'b1;
    line_level <= level;
    pop_request <= pop;
    @(negedge clk);
    while (!rx_taken) @(negedge clk);
    ticks_sent++;
  endtask

  task automatic settle();
    rx_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    if (idx == REG_CYCLES_PER_BIT) cur_cycles = value[15:0];
    else frame_len = (value[3:0] < FRAME_MIN) ? FRAME_MIN :
                     (value[3:0] > FRAME_MAX) ? FRAME_MAX : value[3:0];
  endtask

  // idle high, start bit, data LSB first, parity/extra bits random, then the stop bit
  task automatic send_frame(input logic [7:0] data, input logic stop_bit, input int pct);
    logic [11:0] bits;
    int hold;
    bits = 12'($urandom);
    bits[0] = 1'b0;
    bits[8:1] = data;
    bits[frame_len - 1] = stop_bit;
    repeat ($urandom_range(1, 3)) send_tick(1'b1, rand_pop(pct));
    for (int i = 0; i < frame_len; i++) begin
      hold = (cur_cycles < 2) ? 1 : (cur_cycles > 64) ? $urandom_range(1, 6) : cur_cycles;
      if (hold > 2 && $urandom_range(0, 7) == 0) hold = hold + int'($urandom_range(0, 2)) - 1;
      repeat (hold) send_tick(bits[i], rand_pop(pct));
    end
  endtask

  task automatic run_phase(input logic [15:0] cycles, input logic [3:0] bpf,
                           input int ticks, input int pop_pct, input int noise_pct);
    int target;
    settle();
    write_reg(REG_CYCLES_PER_BIT, {16'd0, cycles});
    write_reg(REG_BITS_PER_FRAME, {28'd0, bpf});
    target = ticks_sent + ticks;
    while (ticks_sent < target) begin
      if ($urandom_range(0, 99) >= noise_pct) begin
        send_frame(8'($urandom), 1'b1, pop_pct);
      end else begin
        case ($urandom_range(0, 3))
          0: send_frame(8'($urandom), 1'b0, pop_pct);
          1: begin
            send_tick(1'b1, rand_pop(pop_pct));
            repeat ($urandom_range(1, 3)) send_tick(1'b0, rand_pop(pop_pct));
          end
          2: repeat ($urandom_range(4, 24)) send_tick(1'($urandom_range(0, 1)),
                                                      rand_pop(pop_pct));
          default: repeat ($urandom_range(1, 12)) send_tick(1'b1, rand_pop(pop_pct));
        endcase
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset settings: pop on empty, falling edge starts a frame
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    settle();

    // tiny bit period, frame length below range
    write_reg(REG_CYCLES_PER_BIT, 32'd1);
    write_reg(REG_BITS_PER_FRAME, 32'd0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);   // high start sample
    send_frame(8'hFF, 1'b1, 0);
    send_frame(8'h00, 1'b0, 0);   // bad stop bit
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);

    run_phase(16'd3, 4'd12, 100, 40, 10);
    run_phase(16'hFFFF, 4'd15, 60, 50, 20);
    run_phase(16'd0, 4'd11, 60, 50, 20);
    run_phase(16'd2, 4'd10, 900, 0, 5);   // fills and overruns the queue
    run_phase(16'd4, 4'd9, 60, 90, 10);
    gaps_on = 1'b0;
    run_phase(16'd5, 4'd11, 100, 60, 10);
    settle();
    repeat (5) @(negedge clk);

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
